@@ hw/rtl/whp_pkg.sv @@
package whp_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       first_byte;
  } whp_in_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_RIFF  = 3'd1,
    ST_NO_WAVE  = 3'd2,
    ST_NO_FMT   = 3'd3,
    ST_COMPRESS = 3'd4,
    ST_UNKNOWN  = 3'd5,
    ST_NO_DATA  = 3'd6
  } whp_status_t;

  typedef struct packed {
    whp_status_t status;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] payload_size;
    logic [1:0]  format_code;
  } whp_out_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TAG1   = 3'd1,
    PH_FACT   = 3'd2,
    PH_TAG2   = 3'd3,
    PH_SIZE   = 3'd4
  } whp_phase_t;

  // request held in the input register
  typedef struct packed {
    logic    valid;
    whp_in_t item;
  } whp_req_t;

  // result leaving the parser
  typedef struct packed {
    logic     valid;
    whp_out_t item;
  } whp_res_t;

  // tag bytes, entry 0 is the first byte in the file
  localparam logic [3:0][7:0] TAG_RIFF = {8'h46, 8'h46, 8'h49, 8'h52};
  localparam logic [3:0][7:0] TAG_WAVE = {8'h45, 8'h56, 8'h41, 8'h57};
  localparam logic [3:0][7:0] TAG_FMT  = {8'h20, 8'h74, 8'h6D, 8'h66};
  localparam logic [3:0][7:0] TAG_DATA = {8'h61, 8'h74, 8'h61, 8'h64};
  localparam logic [31:0]     FACT_WORD = 32'h7463_6166;

  localparam logic [5:0] OFF_RIFF_END = 6'd3;
  localparam logic [5:0] OFF_WAVE_LO  = 6'd8;
  localparam logic [5:0] OFF_WAVE_END = 6'd11;
  localparam logic [5:0] OFF_FMT_LO   = 6'd12;
  localparam logic [5:0] OFF_FMT_HI   = 6'd14;
  localparam logic [5:0] OFF_FMT_END  = 6'd15;
  localparam logic [5:0] OFF_AFMT_END = 6'd21;
  localparam logic [5:0] OFF_CH_END   = 6'd23;
  localparam logic [5:0] OFF_RATE_END = 6'd27;
  localparam logic [5:0] OFF_BITS_END = 6'd35;
  localparam logic [5:0] OFF_FACT_END = 6'd47;
  localparam logic [5:0] OFF_TAG2_LO  = 6'd48;
  localparam logic [5:0] OFF_TAG2_HI  = 6'd51;
  localparam logic [5:0] OFF_LAST     = 6'd55;

endpackage

@@ hw/rtl/wav_header_parser_top.sv @@
// each byte is held in the input register; the result it completes is registered for out_item
// throughput: one file byte per cycle while the result register is free or being taken
// a new byte is taken even while a result waits, until the input register also fills
// reset: synchronous, active low; empties both registers and starts the parse at byte 0
// of a file, so no first_byte flag is needed after reset
module wav_header_parser_top import whp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  whp_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output whp_out_t out_item
);

  whp_req_t req;
  whp_res_t res;
  logic     adv;

  whp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .req      (req)
  );

  whp_parser u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .adv   (adv),
    .res   (res)
  );

  whp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

@@ hw/rtl/whp_in_stage.sv @@
module whp_in_stage import whp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  whp_in_t  in_item,
  input  logic     adv,
  output whp_req_t req
);

  logic    valid_r;
  whp_in_t item_r;

  assign in_stall = valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  assign req.valid = valid_r;
  assign req.item  = item_r;

endmodule

@@ hw/rtl/whp_parser.sv @@
module whp_parser import whp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  whp_req_t req,
  input  logic     adv,
  output whp_res_t res
);

  logic [5:0]  off_r, off_nxt;
  whp_phase_t  ph_r, ph_nxt;
  logic        tok_r, tok_nxt;
  logic [31:0] aw_r, aw_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic        fin_r, fin_nxt;
  logic        fire;

  assign fire = req.valid && adv;

  always_comb begin
    logic [5:0]  off_e;
    whp_phase_t  ph_e;
    logic        tok_e;
    logic [31:0] aw_e;
    logic [15:0] ch_e;
    logic [31:0] rate_e;
    logic [15:0] bits_e;
    logic        fin_e;
    logic [7:0]  b;
    logic [1:0]  k;
    logic        emit;
    whp_status_t st;
    logic [31:0] size;

    off_nxt  = off_r;
    ph_nxt   = ph_r;
    tok_nxt  = tok_r;
    aw_nxt   = aw_r;
    ch_nxt   = ch_r;
    rate_nxt = rate_r;
    bits_nxt = bits_r;
    fin_nxt  = fin_r;
    res      = '0;
    emit     = 1'b0;
    st       = ST_OK;
    size     = '0;
    b        = req.item.file_byte;

    if (req.item.first_byte) begin
      off_e  = '0;
      ph_e   = PH_HEADER;
      tok_e  = 1'b1;
      aw_e   = '0;
      ch_e   = '0;
      rate_e = '0;
      bits_e = '0;
      fin_e  = 1'b0;
    end else begin
      off_e  = off_r;
      ph_e   = ph_r;
      tok_e  = tok_r;
      aw_e   = aw_r;
      ch_e   = ch_r;
      rate_e = rate_r;
      bits_e = bits_r;
      fin_e  = fin_r;
    end
    k = off_e[1:0];

    if (fire) begin
      off_nxt  = off_e;
      ph_nxt   = ph_e;
      tok_nxt  = tok_e;
      aw_nxt   = aw_e;
      ch_nxt   = ch_e;
      rate_nxt = rate_e;
      bits_nxt = bits_e;
      fin_nxt  = fin_e;
      if (!fin_e) begin
        aw_nxt = {b, aw_e[31:8]};
        unique case (ph_e)
          PH_HEADER: begin
            if (off_e <= OFF_RIFF_END && b != TAG_RIFF[k]) tok_nxt = 1'b0;
            if (off_e >= OFF_WAVE_LO && off_e <= OFF_WAVE_END && b != TAG_WAVE[k])
              tok_nxt = 1'b0;
            if (off_e >= OFF_FMT_LO && off_e <= OFF_FMT_HI && b != TAG_FMT[k])
              tok_nxt = 1'b0;
            priority if (off_e == OFF_RIFF_END || off_e == OFF_WAVE_END ||
                         off_e == OFF_FMT_END) begin
              // a failed tag reports on the last byte of its slot
              if (!tok_nxt) begin
                emit = 1'b1;
                priority if (off_e == OFF_RIFF_END) st = ST_NO_RIFF;
                else if (off_e == OFF_WAVE_END) st = ST_NO_WAVE;
                else st = ST_NO_FMT;
              end
              tok_nxt = 1'b1;
            end else if (off_e == OFF_AFMT_END) begin
              if (aw_nxt[31:16] != 16'd1) begin
                emit = 1'b1;
                st   = ST_COMPRESS;
              end
            end else if (off_e == OFF_CH_END) begin
              ch_nxt = aw_nxt[31:16];
            end else if (off_e == OFF_RATE_END) begin
              rate_nxt = aw_nxt;
            end else if (off_e == OFF_BITS_END) begin
              bits_nxt = aw_nxt[31:16];
              ph_nxt   = PH_TAG1;
            end else begin
            end
          end
          PH_TAG1, PH_TAG2: begin
            if (b != TAG_DATA[k]) tok_nxt = 1'b0;
            if (k == 2'd3) begin
              priority if (tok_nxt) begin
                ph_nxt = PH_SIZE;
              end else if (ph_e == PH_TAG1 && aw_nxt == FACT_WORD) begin
                ph_nxt = PH_FACT;
              end else begin
                emit = 1'b1;
                st   = (ph_e == PH_TAG1) ? ST_UNKNOWN : ST_NO_DATA;
              end
              tok_nxt = 1'b1;
            end
          end
          PH_FACT: begin
            if (off_e == OFF_FACT_END) ph_nxt = PH_TAG2;
          end
          PH_SIZE: begin
            if (k == 2'd3) begin
              emit = 1'b1;
              st   = ST_OK;
              size = aw_nxt;
            end
          end
          default: begin
          end
        endcase

        if (emit) begin
          fin_nxt          = 1'b1;
          res.valid        = 1'b1;
          res.item.status  = st;
          if (st == ST_OK) begin
            res.item.channels     = ch_e;
            res.item.sample_rate  = rate_e;
            res.item.sample_bits  = bits_e;
            res.item.payload_size = size;
            res.item.format_code  = {ch_e != 16'd1, bits_e != 16'd8};
          end
        end else begin
          off_nxt = off_e + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      ph_r   <= PH_HEADER;
      tok_r  <= 1'b1;
      aw_r   <= '0;
      ch_r   <= '0;
      rate_r <= '0;
      bits_r <= '0;
      fin_r  <= 1'b0;
    end else begin
      off_r  <= off_nxt;
      ph_r   <= ph_nxt;
      tok_r  <= tok_nxt;
      aw_r   <= aw_nxt;
      ch_r   <= ch_nxt;
      rate_r <= rate_nxt;
      bits_r <= bits_nxt;
      fin_r  <= fin_nxt;
    end
  end

  a_res_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> fire)
    else $error("result without a request being consumed");

  a_quiet_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_r && !req.item.first_byte) |-> !res.valid)
    else $error("result after the parse had finished");

  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    off_r <= OFF_LAST)
    else $error("byte offset ran past the data size");

  a_tag2_window: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_TAG2) |-> (off_r >= OFF_TAG2_LO && off_r <= OFF_TAG2_HI))
    else $error("second data tag outside its slot");

endmodule

@@ hw/rtl/whp_out_stage.sv @@
module whp_out_stage import whp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  whp_res_t res,
  output logic     adv,
  output logic     out_valid,
  input  logic     out_stall,
  output whp_out_t out_item
);

  logic     valid_r;
  whp_out_t item_r;

  // the result register may load when empty or being taken
  assign adv = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      item_r <= res.item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
